// ===== rtl/core/ihp_pkg.sv =====
// ============================================================================
// ihp_pkg - Intel HEX record parser package
// Parser phase codes and the character constants used to decode digits.
// ============================================================================
package ihp_pkg;

    // Parser phase, one-hot
    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_LEN  = 6'b000010,
        PH_ADDR = 6'b000100,
        PH_TYPE = 6'b001000,
        PH_DATA = 6'b010000,
        PH_SKIP = 6'b100000
    } phase_t;

    // Character constants
    localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NINE    = 8'h39;  // '9'
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;  // 'F'
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;  // 'Z'
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;  // 'f'
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;  // 'z'
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] LETTER_BASE  = 8'd10;

endpackage

// ===== rtl/core/ihp_if.sv =====
// ============================================================================
// ihp_if - Intel HEX record parser channel interfaces
// Valid/ready channels for the character stream and the decoded records.
// ============================================================================

// Character stream channel
interface ihp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

// Decoded record channel, one request per data byte or header-only record
interface ihp_rec_if;
    logic        valid;
    logic        ready;
    logic [15:0] record_address;
    logic [7:0]  byte_offset;
    logic [7:0]  data_value;
    logic [7:0]  record_type;
    logic [7:0]  record_length;
    logic        last_in_record;
    logic        header_only;
    logic        bad_digit;

    modport source (
        output valid, output record_address, output byte_offset, output data_value,
        output record_type, output record_length, output last_in_record,
        output header_only, output bad_digit, input ready
    );
    modport sink (
        input valid, input record_address, input byte_offset, input data_value,
        input record_type, input record_length, input last_in_record,
        input header_only, input bad_digit, output ready
    );
endinterface

// ===== rtl/core/intel_hex_record_parser.sv =====
// ============================================================================
// intel_hex_record_parser - streaming Intel HEX record parser
// The result is registered: it is presented in the cycle after the character that completes it.
// Throughput: one character per cycle; a character can be taken in the same cycle
// as the held result drains, so input stalls only while the sink holds a result.
// Reset: rst_n (async, active low) returns the parser to waiting for a record
// start, clears the field registers and drops the result valid.
// ============================================================================
module intel_hex_record_parser (
    input  logic             clk,
    input  logic             rst_n,
    ihp_char_if.sink         chars,
    ihp_rec_if.source        records
);
    import ihp_pkg::*;

    // Parser state
    phase_t      phase_reg,   phase_next;
    logic [1:0]  digit_reg,   digit_next;
    logic [7:0]  length_reg,  length_next;
    logic [15:0] address_reg, address_next;
    logic [7:0]  type_reg,    type_next;
    logic [7:0]  index_reg,   index_next;
    logic [3:0]  high_reg,    high_next;
    logic        bad_reg,     bad_next;

    // Result register
    logic        rvalid_reg;
    logic [15:0] raddr_reg;
    logic [7:0]  roff_reg;
    logic [7:0]  rdata_reg;
    logic [7:0]  rtype_reg;
    logic [7:0]  rlen_reg;
    logic        rlast_reg;
    logic        rhdr_reg;
    logic        rbad_reg;

    // Result of this character
    logic        emit;
    logic [7:0]  e_off;
    logic [7:0]  e_data;
    logic        e_last;
    logic        e_hdr;

    logic        accept;
    logic        is_ws;
    logic        is_hex;
    logic [7:0]  c;
    logic [7:0]  digit_val;
    logic [3:0]  nib;

    assign c      = chars.character;
    assign accept = chars.valid && chars.ready;

    // Take a character whenever the result slot is free or being drained
    assign chars.ready = !rvalid_reg || records.ready;

    // Character classes and digit value
    always_comb
    begin
        is_ws  = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
        is_hex = (c >= CHAR_ZERO && c <= CHAR_NINE) ||
                 (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) ||
                 (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            digit_val = c - CHAR_UPPER_A + LETTER_BASE;
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            digit_val = c - CHAR_LOWER_A + LETTER_BASE;
        else
            digit_val = c - CHAR_ZERO;
        nib = digit_val[3:0];
    end

    // Next-state and result logic
    always_comb
    begin
        phase_next   = phase_reg;
        digit_next   = digit_reg;
        length_next  = length_reg;
        address_next = address_reg;
        type_next    = type_reg;
        index_next   = index_reg;
        high_next    = high_reg;
        bad_next     = bad_reg;
        emit         = 1'b0;
        e_off        = index_reg;
        e_data       = {high_reg, nib};
        e_last       = 1'b0;
        e_hdr        = 1'b0;

        if (is_ws)
        begin
            // whitespace ends any record in progress
            phase_next = PH_IDLE;
            digit_next = 2'd0;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    // start character is skipped; fields cleared
                    length_next  = '0;
                    address_next = '0;
                    type_next    = '0;
                    index_next   = '0;
                    high_next    = '0;
                    bad_next     = 1'b0;
                    digit_next   = 2'd0;
                    phase_next   = PH_LEN;
                end
                PH_LEN:
                begin
                    bad_next    = bad_reg | !is_hex;
                    length_next = {length_reg[3:0], nib};
                    if (digit_reg == 2'd1)
                    begin
                        digit_next = 2'd0;
                        phase_next = PH_ADDR;
                    end
                    else
                        digit_next = 2'd1;
                end
                PH_ADDR:
                begin
                    bad_next     = bad_reg | !is_hex;
                    address_next = {address_reg[11:0], nib};
                    digit_next   = digit_reg + 2'd1;
                    if (digit_reg == 2'd3)
                        phase_next = PH_TYPE;
                end
                PH_TYPE:
                begin
                    bad_next  = bad_reg | !is_hex;
                    type_next = {type_reg[3:0], nib};
                    if (digit_reg == 2'd0)
                        digit_next = 2'd1;
                    else
                    begin
                        digit_next = 2'd0;
                        index_next = '0;
                        if (length_reg == 8'd0)
                        begin
                            // empty record: one header-only result
                            phase_next = PH_SKIP;
                            emit       = 1'b1;
                            e_off      = '0;
                            e_data     = '0;
                            e_last     = 1'b1;
                            e_hdr      = 1'b1;
                        end
                        else
                            phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    bad_next = bad_reg | !is_hex;
                    if (digit_reg == 2'd0)
                    begin
                        high_next  = nib;
                        digit_next = 2'd1;
                    end
                    else
                    begin
                        digit_next = 2'd0;
                        emit       = 1'b1;
                        e_last     = (index_reg == length_reg - 8'd1);
                        if (e_last)
                            phase_next = PH_SKIP;
                        else
                            index_next = index_reg + 8'd1;
                    end
                end
                default:
                begin
                    // checksum and trailing characters are ignored
                end
            endcase
        end
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            digit_reg   <= 2'd0;
            length_reg  <= '0;
            address_reg <= '0;
            type_reg    <= '0;
            index_reg   <= '0;
            high_reg    <= '0;
            bad_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            digit_reg   <= digit_next;
            length_reg  <= length_next;
            address_reg <= address_next;
            type_reg    <= type_next;
            index_reg   <= index_next;
            high_reg    <= high_next;
            bad_reg     <= bad_next;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rvalid_reg <= 1'b0;
        else if (accept && emit)
            rvalid_reg <= 1'b1;
        else if (records.ready)
            rvalid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            raddr_reg <= address_next;
            roff_reg  <= e_off;
            rdata_reg <= e_data;
            rtype_reg <= type_next;
            rlen_reg  <= length_next;
            rlast_reg <= e_last;
            rhdr_reg  <= e_hdr;
            rbad_reg  <= bad_next;
        end
    end

    assign records.valid          = rvalid_reg;
    assign records.record_address = raddr_reg;
    assign records.byte_offset    = roff_reg;
    assign records.data_value     = rdata_reg;
    assign records.record_type    = rtype_reg;
    assign records.record_length  = rlen_reg;
    assign records.last_in_record = rlast_reg;
    assign records.header_only    = rhdr_reg;
    assign records.bad_digit      = rbad_reg;

endmodule
